[src/logic_capture_trigger_engine_defines.svh]
// Assertion macros shared by the capture engine RTL.
// Depends on nothing; the asserting module must provide clk_i and rst_ni.
`ifndef LOGIC_CAPTURE_TRIGGER_ENGINE_DEFINES_SVH
`define LOGIC_CAPTURE_TRIGGER_ENGINE_DEFINES_SVH

// Concurrent check that is switched off while reset is asserted.
`define LCTE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Concurrent check that also holds during reset.
`define LCTE_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

[src/lcte_pkg.sv]
// Shared types and fixed field widths of the logic capture trigger engine.
// Depends on nothing; used by the channel interfaces and the top level.
package lcte_pkg;

  localparam int unsigned ACTION_W   = 2;
  localparam int unsigned LEVELS_W   = 8;
  localparam int unsigned RIDX_W     = 14;
  localparam int unsigned DIV_W      = 24;
  localparam int unsigned COUNT_W    = 15;
  localparam int unsigned EPOCH_W    = 16;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 24;

  localparam logic [COUNT_W-1:0] SAMPLE_COUNT_RST = 15'd16384;

  typedef enum logic [ACTION_W-1:0] {
    ACT_TICK = 2'd0,
    ACT_ARM  = 2'd1,
    ACT_STOP = 2'd2,
    ACT_READ = 2'd3
  } action_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DIVIDER = 2'd0,
    CFG_MASK    = 2'd1,
    CFG_COUNT   = 2'd2
  } cfg_reg_e;

endpackage

[src/lcte_if.sv]
// Valid/ready channel interfaces for the command input and the result output.
// Depends on lcte_pkg for the field widths and the action type.
interface lcte_in_if;
  logic                               valid;
  logic                               ready;
  lcte_pkg::action_e                  action;
  logic [lcte_pkg::LEVELS_W-1:0]      levels;
  logic [lcte_pkg::RIDX_W-1:0]        read_index;

  modport source (output valid, action, levels, read_index, input ready);
  modport sink   (input valid, action, levels, read_index, output ready);
endinterface

interface lcte_out_if;
  logic                               valid;
  logic                               ready;
  logic [lcte_pkg::LEVELS_W-1:0]      read_data;
  logic                               is_armed;
  logic                               is_triggered;
  logic [lcte_pkg::COUNT_W-1:0]       stored_count;
  logic                               done_res;

  modport source (output valid, read_data, is_armed, is_triggered, stored_count, done_res,
                  input ready);
  modport sink   (input valid, read_data, is_armed, is_triggered, stored_count, done_res,
                  output ready);
endinterface

[src/logic_capture_trigger_engine.sv]
// A result appears in the cycle after its command transaction is accepted.
// Throughput: one transaction per cycle unless the sink stalls; the single output
// register then holds a result, and the sample memory read port is registered.
// Reset clears the flags, position, divider count, epoch and registers at once.
// The sample memory is not cleared; entries are tagged with the arm epoch instead.
`include "logic_capture_trigger_engine_defines.svh"

module logic_capture_trigger_engine #(
  parameter int unsigned BUFFER_DEPTH = 16384,
  parameter int unsigned CHANNELS     = 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  lcte_in_if.sink                         in_ch,
  lcte_out_if.source                      out_ch,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [lcte_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [lcte_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  // Only the low eight channels reach the store, since the level field is a byte.
  localparam int unsigned CH_W    = (CHANNELS < 8) ? CHANNELS : 8;
  localparam int unsigned AW      = $clog2(BUFFER_DEPTH);
  localparam int unsigned CW      = lcte_pkg::COUNT_W;
  localparam int unsigned DW      = lcte_pkg::DIV_W;
  localparam int unsigned EW      = lcte_pkg::EPOCH_W;
  localparam int unsigned LW      = lcte_pkg::LEVELS_W;
  localparam int unsigned MEM_W   = EW + CH_W;
  localparam int unsigned WIDE_W  = (AW > CW) ? AW : CW;
  localparam int unsigned CAP_INT = (BUFFER_DEPTH < (1 << CW)) ? BUFFER_DEPTH
                                                                : ((1 << CW) - 1);
  localparam logic [CW-1:0] CNT_CAP = CW'(CAP_INT);

  // Configuration registers. Writes are always taken at once.
  logic [DW-1:0]   div_cfg_q;
  logic [CH_W-1:0] mask_cfg_q;
  logic [CW-1:0]   cnt_cfg_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_cfg_q  <= '0;
      mask_cfg_q <= '0;
      cnt_cfg_q  <= lcte_pkg::SAMPLE_COUNT_RST;
    end else if (cfg_valid_i) begin
      case (lcte_pkg::cfg_reg_e'(cfg_index_i))
        lcte_pkg::CFG_DIVIDER: div_cfg_q  <= cfg_data_i[DW-1:0];
        lcte_pkg::CFG_MASK:    mask_cfg_q <= cfg_data_i[CH_W-1:0];
        lcte_pkg::CFG_COUNT:   cnt_cfg_q  <= cfg_data_i[CW-1:0];
        default: ;
      endcase
    end
  end

  // Capture control state. The arm epoch tags each stored sample so that a new
  // capture sees the entries of older captures as empty without a clearing pass.
  logic            armed_q, armed_d;
  logic            trig_q, trig_d;
  logic [CH_W-1:0] prev_q, prev_d;
  logic [CW-1:0]   pos_q, pos_d;
  logic [DW-1:0]   div_q, div_d;
  logic [EW-1:0]   epoch_q, epoch_d;

  // Output stage: one result register, and the registered memory read data.
  logic             out_valid_q;
  logic             done_q, done_d;
  logic             rd_hit_q, rd_hit_d;
  logic [MEM_W-1:0] rd_data_q;

  logic in_acc;
  assign in_ch.ready = !out_valid_q || out_ch.ready;
  assign in_acc      = in_ch.valid && in_ch.ready;

  // Effective count: zero acts as one, and the buffer depth caps it.
  logic [CW-1:0] eff_cnt;
  always_comb begin
    if (cnt_cfg_q == '0) begin
      eff_cnt = CW'(1);
    end else if (cnt_cfg_q > CNT_CAP) begin
      eff_cnt = CNT_CAP;
    end else begin
      eff_cnt = cnt_cfg_q;
    end
  end

  // Samples land newest-first: position p goes to entry count-1-p.
  logic [CW-1:0]     slot_n;
  logic [WIDE_W-1:0] slot_wide;
  logic [CW-1:0]     pos_inc;
  assign slot_n    = eff_cnt - CW'(1) - pos_q;
  assign slot_wide = WIDE_W'(slot_n);
  assign pos_inc   = pos_q + CW'(1);

  logic [31:0]     ridx_ext;
  logic [CH_W-1:0] lv;
  logic [CH_W-1:0] mask_m;
  assign ridx_ext = 32'(in_ch.read_index);
  assign lv       = in_ch.levels[CH_W-1:0];
  assign mask_m   = mask_cfg_q;

  logic             wr_en, rd_en, take;
  logic [AW-1:0]    wr_addr, rd_addr;
  logic [MEM_W-1:0] wr_data;

  assign wr_addr = slot_wide[AW-1:0];
  assign rd_addr = ridx_ext[AW-1:0];
  assign wr_data = {epoch_q, lv};

  always_comb begin
    armed_d  = armed_q;
    trig_d   = trig_q;
    prev_d   = prev_q;
    pos_d    = pos_q;
    div_d    = div_q;
    epoch_d  = epoch_q;
    done_d   = done_q;
    rd_hit_d = rd_hit_q;
    wr_en    = 1'b0;
    rd_en    = 1'b0;
    take     = 1'b0;
    if (in_acc) begin
      done_d   = 1'b0;
      rd_hit_d = 1'b0;
      case (in_ch.action)
        lcte_pkg::ACT_TICK: begin
          if (!armed_q) begin
            // Idle ticks keep tracking the pins so the first armed tick compares
            // against the latest levels.
            prev_d = lv;
            trig_d = 1'b0;
          end else begin
            if (!trig_q) begin
              if ((mask_m == '0) || ((lv & mask_m) != (prev_q & mask_m))) begin
                trig_d = 1'b1;
                take   = 1'b1;
              end
              prev_d = lv;
            end else if (div_q != '0) begin
              div_d = div_q - DW'(1);
            end else begin
              take = 1'b1;
            end
            if (take) begin
              if (pos_q < eff_cnt) begin
                wr_en = 1'b1;
                pos_d = pos_inc;
                div_d = div_cfg_q;
              end
              // A count lowered below the position ends the capture too.
              if (pos_d >= eff_cnt) begin
                armed_d = 1'b0;
                done_d  = 1'b1;
              end
            end
          end
        end
        lcte_pkg::ACT_ARM: begin
          armed_d = 1'b1;
          trig_d  = 1'b0;
          pos_d   = '0;
          div_d   = '0;
          epoch_d = epoch_q + EW'(1);
        end
        lcte_pkg::ACT_STOP: begin
          if (armed_q) begin
            armed_d = 1'b0;
            done_d  = 1'b1;
          end
        end
        lcte_pkg::ACT_READ: begin
          rd_en    = 1'b1;
          rd_hit_d = (ridx_ext < BUFFER_DEPTH);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q     <= 1'b0;
      trig_q      <= 1'b0;
      prev_q      <= '0;
      pos_q       <= '0;
      div_q       <= '0;
      epoch_q     <= '0;
      out_valid_q <= 1'b0;
      done_q      <= 1'b0;
      rd_hit_q    <= 1'b0;
    end else begin
      armed_q  <= armed_d;
      trig_q   <= trig_d;
      prev_q   <= prev_d;
      pos_q    <= pos_d;
      div_q    <= div_d;
      epoch_q  <= epoch_d;
      done_q   <= done_d;
      rd_hit_q <= rd_hit_d;
      if (in_acc) begin
        out_valid_q <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Sample memory: one write port and one registered read port. Only one
  // transaction enters per cycle, so a write and a read never meet in one cycle.
  logic [MEM_W-1:0] mem_q [BUFFER_DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  // The status fields come straight from the state registers: no newer
  // transaction is accepted until the current result leaves. An entry counts as
  // filled only when its epoch tag matches the current capture.
  logic rd_valid_entry;
  assign rd_valid_entry = rd_hit_q && (rd_data_q[MEM_W-1 -: EW] == epoch_q);

  assign out_ch.valid        = out_valid_q;
  assign out_ch.read_data    = rd_valid_entry ? LW'(rd_data_q[CH_W-1:0]) : '0;
  assign out_ch.is_armed     = armed_q;
  assign out_ch.is_triggered = trig_q;
  assign out_ch.stored_count = pos_q;
  assign out_ch.done_res     = done_q;

  `LCTE_ASSERT(a_done_disarms, out_valid_q && done_q |-> !armed_q,
               "done result while still armed")
  `LCTE_ASSERT(a_arm_restarts,
               in_acc && (in_ch.action == lcte_pkg::ACT_ARM)
                 |=> armed_q && !trig_q && (pos_q == '0),
               "arm did not restart the capture")
  `LCTE_ASSERT(a_store_after_trigger, wr_en |=> trig_q,
               "sample stored without a trigger")
  `LCTE_ASSERT(a_position_steps,
               pos_q != $past(pos_q)
                 |-> (pos_q == '0) || (pos_q == $past(pos_q) + 1'b1),
               "write position jumped")

endmodule

[test/lcte_capture_tracker_pkg.sv]
// Status tracker for the logic capture engine testbench: a cycle-free model of the capture
// state plus the queue of status words still owed by the block. Depends on lcte_pkg.
package lcte_capture_tracker_pkg;
  import lcte_pkg::*;

  localparam int unsigned SAMPLE_SLOTS = 16384;

  typedef struct packed {
    logic [LEVELS_W-1:0] read_data;
    logic                armed;
    logic                triggered;
    logic [COUNT_W-1:0]  stored;
    logic                done;
  } capture_status_t;

  class capture_tracker;
    logic [LEVELS_W-1:0] samples [SAMPLE_SLOTS];
    int unsigned         fill_epoch [SAMPLE_SLOTS];
    bit                  ever_written [SAMPLE_SLOTS];
    int unsigned         written_slots [$];
    int unsigned         epoch;
    bit                  armed;
    bit                  triggered;
    logic [LEVELS_W-1:0] last_levels;
    int unsigned         position;
    logic [DIV_W-1:0]    div_left;
    logic [DIV_W-1:0]    divider;
    logic [LEVELS_W-1:0] mask;
    logic [COUNT_W-1:0]  count;
    capture_status_t     pending_status [$];
    int unsigned         mismatches;

    function new();
      // Epoch zero is never current, so nothing reads as filled before the first arm.
      epoch       = 1;
      armed       = 0;
      triggered   = 0;
      last_levels = '0;
      position    = 0;
      div_left    = '0;
      divider     = '0;
      mask        = '0;
      count       = SAMPLE_COUNT_RST;
      mismatches  = 0;
    endfunction

    function void write_register(cfg_reg_e idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_DIVIDER: divider = data[DIV_W-1:0];
        CFG_MASK:    mask    = data[LEVELS_W-1:0];
        CFG_COUNT:   count   = data[COUNT_W-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned active_count();
      if (count == 0) return 1;
      if (count > SAMPLE_SLOTS) return SAMPLE_SLOTS;
      return count;
    endfunction

    function bit was_written(int unsigned idx);
      return ever_written[idx];
    endfunction

    function void note_command(action_e act, logic [LEVELS_W-1:0] lv, logic [RIDX_W-1:0] ridx);
      capture_status_t s;
      bit              take;
      int unsigned     cnt;
      int unsigned     slot;
      s    = '0;
      take = 0;
      case (act)
        ACT_TICK: begin
          if (!armed) begin
            last_levels = lv;
            triggered   = 0;
          end else begin
            if (!triggered) begin
              if (mask == 0 || (lv & mask) != (last_levels & mask)) begin
                triggered = 1;
                take      = 1;
              end
              last_levels = lv;
            end else if (div_left != 0) begin
              div_left--;
            end else begin
              take = 1;
            end
            if (take) begin
              cnt = active_count();
              if (position < cnt) begin
                slot             = cnt - 1 - position;
                samples[slot]    = lv;
                fill_epoch[slot] = epoch;
                if (!ever_written[slot]) begin
                  ever_written[slot] = 1;
                  written_slots.push_back(slot);
                end
                position++;
                div_left = divider;
              end
              if (position >= cnt) begin
                armed  = 0;
                s.done = 1;
              end
            end
          end
        end
        ACT_ARM: begin
          armed     = 1;
          triggered = 0;
          position  = 0;
          div_left  = '0;
          epoch++;
        end
        ACT_STOP: begin
          if (armed) begin
            armed  = 0;
            s.done = 1;
          end
        end
        default: begin
          if (fill_epoch[ridx] == epoch) s.read_data = samples[ridx];
        end
      endcase
      s.armed     = armed;
      s.triggered = triggered;
      s.stored    = position[COUNT_W-1:0];
      pending_status.push_back(s);
    endfunction

    function void compare_field(string name, logic [COUNT_W-1:0] want, logic [COUNT_W-1:0] got,
                                realtime stamp);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", stamp, name, want, got);
        mismatches++;
      end
    endfunction

    function void check_status(capture_status_t got, realtime stamp);
      capture_status_t want;
      if (pending_status.size() == 0) begin
        $display("%0t: status with no command outstanding, actual %h", stamp, got);
        mismatches++;
        return;
      end
      want = pending_status.pop_front();
      compare_field("read_data", want.read_data, got.read_data, stamp);
      compare_field("is_armed", want.armed, got.armed, stamp);
      compare_field("is_triggered", want.triggered, got.triggered, stamp);
      compare_field("stored_count", want.stored, got.stored, stamp);
      compare_field("done_res", want.done, got.done, stamp);
    endfunction
  endclass

endpackage

[test/logic_capture_trigger_engine_test.sv]
// Top-level testbench of the logic capture trigger engine: directed and random command streams
// with random stalls on both channels, checked against the capture tracker.
// Depends on lcte_pkg, the channel interfaces and lcte_capture_tracker_pkg.
module logic_capture_trigger_engine_test;
  timeunit 1ns;
  timeprecision 1ps;

  import lcte_pkg::*;
  import lcte_capture_tracker_pkg::*;

  localparam int unsigned RANDOM_ITEMS    = 1610;
  localparam int unsigned HOLD_OFF_CYCLES = 300;
  localparam int unsigned QUIET_LIMIT     = 4000;
  localparam int unsigned DRAIN_CYCLES    = 8;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  lcte_in_if  cmd_ch ();
  lcte_out_if status_ch ();

  capture_tracker tracker = new();

  // When set, the matching side never idles. The hold-off request asks the status sink to
  // refuse results for a long stretch while commands keep coming.
  bit in_calm;
  bit out_calm;
  bit hold_off_req;

  logic_capture_trigger_engine i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_ch       (cmd_ch),
    .out_ch      (status_ch),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Gap lengths: mostly none, sometimes a few cycles, rarely a long pause.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // Sends one command transaction and records it in the tracker at the edge where it is
  // accepted. With no gap, valid stays high from the previous transaction.
  task automatic send_command(action_e act, logic [LEVELS_W-1:0] lv, logic [RIDX_W-1:0] ridx);
    int unsigned gap;
    gap = in_calm ? 0 : pick_gap();
    if (gap > 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    cmd_ch.valid      <= 1'b1;
    cmd_ch.action     <= act;
    cmd_ch.levels     <= lv;
    cmd_ch.read_index <= ridx;
    do @(posedge clk_i); while (cmd_ch.ready !== 1'b1);
    tracker.note_command(act, lv, ridx);
  endtask

  task automatic write_register(cfg_reg_e idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk_i); while (cfg_ready !== 1'b1);
    tracker.write_register(idx, data);
  endtask

  // Registers change only once every owed status word has come back. The capture itself may
  // still be armed, which is how a count lowered in the middle of a capture is reached.
  task automatic apply_settings(logic [CFG_DATA_W-1:0] divider, logic [CFG_DATA_W-1:0] mask_word,
                                logic [CFG_DATA_W-1:0] count_word);
    cmd_ch.valid <= 1'b0;
    while (tracker.pending_status.size() != 0) @(posedge clk_i);
    write_register(CFG_DIVIDER, divider);
    write_register(CFG_MASK, mask_word);
    write_register(CFG_COUNT, count_word);
    cfg_valid <= 1'b0;
  endtask

  // Reads only ever touch entries that were written at some point since reset, because the
  // memory and its epoch tags start out undefined. Most reads land inside the current count.
  function automatic logic [RIDX_W-1:0] pick_read_index();
    int unsigned idx;
    idx = $urandom_range(tracker.active_count() - 1);
    if (!tracker.was_written(idx))
      idx = tracker.written_slots[$urandom_range(tracker.written_slots.size() - 1)];
    return idx[RIDX_W-1:0];
  endfunction

  // One random command. Ticks dominate so that captures trigger and fill; the levels mostly
  // hold steady so that a watched change, and so the trigger, is not immediate.
  task automatic send_random_item(ref logic [LEVELS_W-1:0] levels_now);
    int unsigned r;
    action_e     act;
    r = $urandom_range(99);
    if (r < 5) begin
      act = ACT_ARM;
    end else if (r < 10) begin
      act = ACT_STOP;
    end else if (r < 28 && tracker.written_slots.size() != 0) begin
      act = ACT_READ;
    end else begin
      act = ACT_TICK;
    end
    if ($urandom_range(9) < 3) levels_now = $urandom_range(255);
    send_command(act, (act == ACT_TICK) ? levels_now : LEVELS_W'($urandom_range(255)),
                 (act == ACT_READ) ? pick_read_index() : RIDX_W'($urandom_range(16383)));
  endtask

  // Status sink: random stalls, with one long hold-off when the stimulus asks for it. Every
  // step drives ready exactly once.
  initial begin : status_sink
    int unsigned stall;
    stall = 0;
    status_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        stall        = HOLD_OFF_CYCLES;
      end
      if (stall > 0) begin
        status_ch.ready <= 1'b0;
        stall--;
      end else begin
        status_ch.ready <= 1'b1;
        if (!out_calm) stall = pick_gap();
      end
    end
  end

  // Every accepted status transaction is checked against the oldest owed status word.
  always @(posedge clk_i) begin : status_monitor
    capture_status_t got;
    if (rst_ni === 1'b1 && status_ch.valid === 1'b1 && status_ch.ready === 1'b1) begin
      got.read_data = status_ch.read_data;
      got.armed     = status_ch.is_armed;
      got.triggered = status_ch.is_triggered;
      got.stored    = status_ch.stored_count;
      got.done      = status_ch.done_res;
      tracker.check_status(got, $realtime);
    end
  end

  // Watchdog: ends the run when no transaction of any channel has happened for too long.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((cmd_ch.valid === 1'b1 && cmd_ch.ready === 1'b1) ||
          (status_ch.valid === 1'b1 && status_ch.ready === 1'b1) ||
          (cfg_valid === 1'b1 && cfg_ready === 1'b1))
        quiet = 0;
      else
        quiet++;
    end
    $display("** logic_capture_trigger_engine: FAILED **");
    $finish;
  end

  initial begin : stimulus
    logic [LEVELS_W-1:0]   levels_now;
    logic [CFG_DATA_W-1:0] divider;
    logic [CFG_DATA_W-1:0] count_word;
    int unsigned           random_sent;
    int unsigned           phase;
    int unsigned           r;

    cmd_ch.valid      <= 1'b0;
    cmd_ch.action     <= ACT_TICK;
    cmd_ch.levels     <= '0;
    cmd_ch.read_index <= '0;
    cfg_valid         <= 1'b0;
    cfg_index         <= CFG_DIVIDER;
    cfg_data          <= '0;
    in_calm           = 1'b0;
    out_calm          = 1'b0;
    hold_off_req      = 1'b0;
    rst_ni            <= 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: idle tick and stop while disarmed, a held-off trigger on a full mask, a short
    // capture read back, reads of entries from an older capture, and a re-arm while armed.
    apply_settings(24'd0, 24'h0000FF, 24'd4);
    send_command(ACT_TICK, 8'h00, 14'd0);
    send_command(ACT_STOP, 8'hFF, 14'h3FFF);
    send_command(ACT_ARM, 8'h00, 14'd0);
    send_command(ACT_TICK, 8'h00, 14'd0);
    send_command(ACT_TICK, 8'h00, 14'd0);
    send_command(ACT_TICK, 8'hFF, 14'd0);
    send_command(ACT_TICK, 8'hA5, 14'd0);
    send_command(ACT_TICK, 8'h5A, 14'd0);
    send_command(ACT_TICK, 8'h3C, 14'd0);
    for (int unsigned i = 0; i < 4; i++) send_command(ACT_READ, 8'h00, RIDX_W'(i));
    send_command(ACT_ARM, 8'h00, 14'd0);
    send_command(ACT_READ, 8'h00, 14'd0);
    send_command(ACT_TICK, 8'h81, 14'd0);
    send_command(ACT_ARM, 8'h00, 14'd0);
    send_command(ACT_TICK, 8'h81, 14'd0);
    send_command(ACT_STOP, 8'h00, 14'd0);
    send_command(ACT_READ, 8'h00, 14'd3);

    // Count lowered in the middle of a capture, to zero, which acts as one: the next sample
    // tick ends the capture without storing.
    apply_settings(24'd1, 24'd0, 24'd8);
    send_command(ACT_ARM, 8'h00, 14'd0);
    repeat (3) send_command(ACT_TICK, 8'h5A, 14'd0);
    apply_settings(24'd1, 24'd0, 24'd0);
    send_command(ACT_TICK, 8'hC3, 14'd0);
    send_command(ACT_TICK, 8'hC3, 14'd0);
    send_command(ACT_READ, 8'h00, 14'd7);

    // All-ones divider and count words: the largest divider and a count above the buffer depth.
    apply_settings(24'hFFFFFF, 24'hFFFF80, 24'hFFFFFF);
    send_command(ACT_ARM, 8'h00, 14'd0);
    send_command(ACT_TICK, 8'h00, 14'd0);
    send_command(ACT_TICK, 8'h80, 14'd0);
    repeat (3) send_command(ACT_TICK, 8'h7F, 14'd0);
    send_command(ACT_STOP, 8'h00, 14'd0);

    // Random phases: each writes all registers, usually arms, and then runs a stream of
    // mostly ticks. Counts stay small apart from a few large ones.
    levels_now  = 8'h00;
    random_sent = 0;
    phase       = 0;
    while (random_sent < RANDOM_ITEMS) begin
      r = $urandom_range(99);
      if (r < 60) divider = $urandom_range(2);
      else if (r < 90) divider = $urandom_range(7, 3);
      else divider = $urandom_range(24'hFFFFFF);
      r = $urandom_range(99);
      count_word = {CFG_DATA_W'($urandom_range(511)) << COUNT_W};
      if (r < 5) count_word[COUNT_W-1:0] = $urandom_range(15'h7FFF);
      else if (r < 10) count_word[COUNT_W-1:0] = '0;
      else count_word[COUNT_W-1:0] = $urandom_range(20, 1);
      r = $urandom_range(9);
      apply_settings(divider,
                     {CFG_DATA_W'($urandom_range(65535)) << LEVELS_W} |
                       ((r < 2) ? 24'd0 : (r < 3) ? 24'hFF : CFG_DATA_W'($urandom_range(255))),
                     count_word);
      in_calm  = ($urandom_range(3) == 0);
      out_calm = ($urandom_range(3) == 0);
      if (phase == 4) begin
        // The sender keeps offering commands while the sink holds off, so the block fills.
        in_calm      = 1'b1;
        hold_off_req = 1'b1;
      end
      if ($urandom_range(3) != 0) begin
        send_command(ACT_ARM, LEVELS_W'($urandom_range(255)), RIDX_W'($urandom_range(16383)));
        random_sent++;
      end
      repeat ($urandom_range(60, 15)) begin
        send_random_item(levels_now);
        random_sent++;
      end
      phase++;
    end

    // Wait until every owed status word has arrived, then a little longer for strays.
    cmd_ch.valid <= 1'b0;
    while (tracker.pending_status.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (tracker.mismatches == 0 && tracker.pending_status.size() == 0) begin
      $display("** logic_capture_trigger_engine: PASSED **");
    end else begin
      $display("** logic_capture_trigger_engine: FAILED **");
    end
    $finish;
  end

endmodule
